>>> rtl/hpbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header block parser package
// Shared item types, parse state, result kind codes and error codes.
// ----------------------------------------------------------------------------
package hpbp_pkg;

   localparam int INT_BITS = 32;

   localparam logic [2:0] KIND_INDEXED    = 3'd0;
   localparam logic [2:0] KIND_LIT_INCR   = 3'd1;
   localparam logic [2:0] KIND_LIT_PLAIN  = 3'd2;
   localparam logic [2:0] KIND_SIZE_UPD   = 3'd3;
   localparam logic [2:0] KIND_NAME_HDR   = 3'd4;
   localparam logic [2:0] KIND_VALUE_HDR  = 3'd5;
   localparam logic [2:0] KIND_STR_BYTE   = 3'd6;
   localparam logic [2:0] KIND_ERROR      = 3'd7;

   localparam logic [31:0] ERR_OVERFLOW  = 32'd1;
   localparam logic [31:0] ERR_TRUNCATED = 32'd2;

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_IDX     = 4'd1,
      PH_INCR    = 4'd2,
      PH_PLAIN   = 4'd3,
      PH_SIZE    = 4'd4,
      PH_LEN     = 4'd5,
      PH_LEN_RAW = 4'd6,
      PH_LEN_HUF = 4'd7,
      PH_DATA    = 4'd8,
      PH_SKIP    = 4'd9
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] number;
      logic [7:0]  string_byte;
      logic        huffman;
      logic        last_byte;
   } rsp_type;

   typedef struct packed {
      phase_type             phase;
      logic [INT_BITS-1:0]   acc;
      logic [5:0]            shift;
      logic [31:0]           bytes_remaining;
      logic                  string_is_value;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_START,
      acc:             '0,
      shift:           '0,
      bytes_remaining: '0,
      string_is_value: 1'b0
   };

endpackage

>>> rtl/hpack_header_block_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header block parser
// Splits header block bytes into representation, string header, string byte
// and error items, one byte per cycle while the output register is free.
// ----------------------------------------------------------------------------
// Each byte is held in in_ff; its result item is registered in rsp_ff.
// The step logic is combinational; st_ff updates as each byte advances.
// Bytes that cause no result pass through without using the output register.
// Reset clears the parse state and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module hpack_header_block_parser_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hpbp_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hpbp_pkg::rsp_type rsp_item
);
   import hpbp_pkg::*;

   req_type   in_ff;
   logic      in_valid_ff;
   state_type st_ff;
   state_type st_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      ev_valid;
   logic      out_free;
   logic      advance;

   hpbp_step u_step (
      .st       (st_ff),
      .item     (in_ff),
      .st_in    (st_in),
      .ev_valid (ev_valid),
      .ev       (rsp_in)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= STATE_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            st_ff <= st_in;
         end
         if (out_free) begin
            rsp_valid_ff <= advance && ev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_item;
      end
      if (advance && ev_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> rtl/hpbp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header block parser step logic
// Computes the next parse state and the optional result item for one byte.
// ----------------------------------------------------------------------------
module hpbp_step (
   input  hpbp_pkg::state_type st,
   input  hpbp_pkg::req_type   item,
   output hpbp_pkg::state_type st_in,
   output logic                ev_valid,
   output hpbp_pkg::rsp_type   ev
);
   import hpbp_pkg::*;

   localparam logic [INT_BITS-1:0] LIM = {INT_BITS{1'b1}};

   logic [7:0]          b;
   logic [INT_BITS-1:0] g_ext;
   logic [INT_BITS-1:0] room;
   logic [INT_BITS-1:0] shifted;
   logic [INT_BITS:0]   sum;
   logic                int_ovf;
   logic [INT_BITS-1:0] int_val;
   logic [5:0]          shift_next;
   logic [31:0]         br_dec;

   logic                overflow;
   logic                fin_rep;
   logic [2:0]          rep_kind;
   logic [INT_BITS-1:0] rep_val;
   logic                fin_len;
   logic [INT_BITS-1:0] len_val;
   logic                len_huf;
   logic                do_after;

   assign b          = item.data_byte;
   assign g_ext      = INT_BITS'(b[6:0]);
   assign room       = LIM >> st.shift;
   assign shifted    = g_ext << st.shift;
   assign sum        = {1'b0, st.acc} + {1'b0, shifted};
   assign int_ovf    = (g_ext > room) || sum[INT_BITS];
   assign int_val    = sum[INT_BITS-1:0];
   assign shift_next = (st.shift <= 6'd56) ? (st.shift + 6'd7) : 6'd63;
   assign br_dec     = st.bytes_remaining - 32'(st.bytes_remaining != 32'd0);

   always_comb begin
      st_in    = st;
      ev_valid = 1'b0;
      ev       = '0;
      overflow = 1'b0;
      fin_rep  = 1'b0;
      rep_kind = KIND_INDEXED;
      rep_val  = '0;
      fin_len  = 1'b0;
      len_val  = '0;
      len_huf  = 1'b0;
      do_after = 1'b0;

      unique case (st.phase)
         PH_IDX, PH_INCR, PH_PLAIN, PH_SIZE: begin
            if (int_ovf) begin
               overflow = 1'b1;
            end else begin
               st_in.acc = int_val;
               if (!b[7]) begin
                  fin_rep = 1'b1;
                  rep_val = int_val;
                  unique case (st.phase)
                     PH_IDX:   rep_kind = KIND_INDEXED;
                     PH_INCR:  rep_kind = KIND_LIT_INCR;
                     PH_PLAIN: rep_kind = KIND_LIT_PLAIN;
                     default:  rep_kind = KIND_SIZE_UPD;
                  endcase
               end else begin
                  st_in.shift = shift_next;
               end
            end
         end
         PH_LEN: begin
            if (b[6:0] != 7'h7f) begin
               fin_len = 1'b1;
               len_val = INT_BITS'(b[6:0]);
               len_huf = b[7];
            end else begin
               st_in.acc   = INT_BITS'(7'h7f);
               st_in.shift = '0;
               st_in.phase = b[7] ? PH_LEN_HUF : PH_LEN_RAW;
            end
         end
         PH_LEN_RAW, PH_LEN_HUF: begin
            if (int_ovf) begin
               overflow = 1'b1;
            end else begin
               st_in.acc = int_val;
               if (!b[7]) begin
                  fin_len = 1'b1;
                  len_val = int_val;
                  len_huf = (st.phase == PH_LEN_HUF);
               end else begin
                  st_in.shift = shift_next;
               end
            end
         end
         PH_DATA: begin
            ev_valid              = 1'b1;
            ev.kind               = KIND_STR_BYTE;
            ev.string_byte        = b;
            st_in.bytes_remaining = br_dec;
            if (br_dec == 32'd0) begin
               ev.last_byte = 1'b1;
               do_after     = 1'b1;
            end
         end
         PH_SKIP: begin
         end
         default: begin
            st_in.shift = '0;
            if (b[7]) begin
               if (b[6:0] != 7'h7f) begin
                  fin_rep  = 1'b1;
                  rep_kind = KIND_INDEXED;
                  rep_val  = INT_BITS'(b[6:0]);
               end else begin
                  st_in.acc   = INT_BITS'(b[6:0]);
                  st_in.phase = PH_IDX;
               end
            end else if (b[6]) begin
               if (b[5:0] != 6'h3f) begin
                  fin_rep  = 1'b1;
                  rep_kind = KIND_LIT_INCR;
                  rep_val  = INT_BITS'(b[5:0]);
               end else begin
                  st_in.acc   = INT_BITS'(b[5:0]);
                  st_in.phase = PH_INCR;
               end
            end else if (b[5]) begin
               if (b[4:0] != 5'h1f) begin
                  fin_rep  = 1'b1;
                  rep_kind = KIND_SIZE_UPD;
                  rep_val  = INT_BITS'(b[4:0]);
               end else begin
                  st_in.acc   = INT_BITS'(b[4:0]);
                  st_in.phase = PH_SIZE;
               end
            end else begin
               if (b[3:0] != 4'hf) begin
                  fin_rep  = 1'b1;
                  rep_kind = KIND_LIT_PLAIN;
                  rep_val  = INT_BITS'(b[3:0]);
               end else begin
                  st_in.acc   = INT_BITS'(b[3:0]);
                  st_in.phase = PH_PLAIN;
               end
            end
         end
      endcase

      if (fin_rep) begin
         ev_valid  = 1'b1;
         ev        = '0;
         ev.kind   = rep_kind;
         ev.number = 32'(rep_val);
         if (rep_kind == KIND_LIT_INCR || rep_kind == KIND_LIT_PLAIN) begin
            st_in.string_is_value = (rep_val != '0);
            st_in.phase           = PH_LEN;
         end else begin
            st_in.phase = PH_START;
         end
      end

      if (fin_len) begin
         ev_valid              = 1'b1;
         ev                    = '0;
         ev.kind               = st.string_is_value ? KIND_VALUE_HDR : KIND_NAME_HDR;
         ev.number             = 32'(len_val);
         ev.huffman            = len_huf;
         st_in.bytes_remaining = 32'(len_val);
         if (32'(len_val) == 32'd0) begin
            do_after = 1'b1;
         end else begin
            st_in.phase = PH_DATA;
         end
      end

      if (do_after) begin
         if (!st_in.string_is_value) begin
            st_in.string_is_value = 1'b1;
            st_in.phase           = PH_LEN;
         end else begin
            st_in.phase = PH_START;
         end
      end

      if (overflow) begin
         ev_valid    = 1'b1;
         ev          = '0;
         ev.kind     = KIND_ERROR;
         ev.number   = ERR_OVERFLOW;
         st_in.phase = PH_SKIP;
      end

      if (item.block_end) begin
         if (st_in.phase != PH_START && st_in.phase != PH_SKIP && !overflow) begin
            ev_valid  = 1'b1;
            ev        = '0;
            ev.kind   = KIND_ERROR;
            ev.number = ERR_TRUNCATED;
         end
         st_in = STATE_RESET;
      end
   end

endmodule

>>> test/hpbp_event_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header block parser event checker
// Watches both item channels of the parser. It decodes every accepted byte
// with its own copy of the parse state, queues the event that the byte should
// produce, and compares each result item field by field with the oldest
// queued event.
// ----------------------------------------------------------------------------
module hpbp_event_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  hpbp_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  hpbp_pkg::rsp_type rsp_item,
   output int                fail_count,
   output int                pending
);

   import hpbp_pkg::*;

   localparam logic [63:0] INT_MAX = (64'd1 << INT_BITS) - 64'd1;

   phase_type   parse_phase;
   logic [63:0] acc_int;
   int          shift_cnt;
   bit          name_pending;
   logic [31:0] bytes_left;
   bit          is_value;

   rsp_type     ev;
   bit          ev_has;
   rsp_type     expected_events [$];
   rsp_type     want;
   int          fails = 0;
   int          queued = 0;

   assign fail_count = fails;
   assign pending    = queued;

   function automatic void clear_state();
      parse_phase  = PH_START;
      acc_int      = '0;
      shift_cnt    = 0;
      name_pending = 1'b0;
      bytes_left   = '0;
      is_value     = 1'b0;
   endfunction

   function automatic void post_event(input logic [2:0] kind, input logic [63:0] num);
      ev_has    = 1'b1;
      ev        = '0;
      ev.kind   = kind;
      ev.number = num[31:0];
   endfunction

   // Returns 0 when the integer is complete, 1 when more groups follow and
   // 2 on overflow.
   function automatic int add_group(input logic [7:0] b);
      logic [63:0] grp;
      logic [63:0] room;
      grp  = {57'd0, b[6:0]};
      room = (shift_cnt < 64) ? (INT_MAX >> shift_cnt) : 64'd0;
      if (grp > room)
         return 2;
      acc_int = acc_int + (grp << shift_cnt);
      if (acc_int > INT_MAX)
         return 2;
      if (!b[7])
         return 0;
      shift_cnt = (shift_cnt <= 56) ? shift_cnt + 7 : 63;
      return 1;
   endfunction

   function automatic void after_string();
      if (!is_value) begin
         is_value     = 1'b1;
         name_pending = 1'b0;
         parse_phase  = PH_LEN;
      end else begin
         parse_phase = PH_START;
      end
   endfunction

   function automatic void finish_rep(input logic [2:0] kind, input logic [63:0] value);
      post_event(kind, value);
      if (kind == KIND_LIT_INCR || kind == KIND_LIT_PLAIN) begin
         name_pending = (value == 0);
         is_value     = !name_pending;
         parse_phase  = PH_LEN;
      end else begin
         parse_phase = PH_START;
      end
   endfunction

   function automatic void finish_len(input logic [63:0] value, input logic huf);
      post_event(is_value ? KIND_VALUE_HDR : KIND_NAME_HDR, value);
      ev.huffman = huf;
      bytes_left = value[31:0];
      if (bytes_left == 0)
         after_string();
      else
         parse_phase = PH_DATA;
   endfunction

   function automatic void start_int(input phase_type ph, input logic [7:0] b,
                                     input logic [7:0] mask);
      acc_int     = {56'd0, b & mask};
      shift_cnt   = 0;
      parse_phase = ph;
   endfunction

   function automatic void decode_byte(input req_type r);
      logic [7:0] b;
      logic [2:0] rep_kind;
      bit         ovf;
      int         st;
      b      = r.data_byte;
      ovf    = 1'b0;
      ev_has = 1'b0;
      ev     = '0;
      case (parse_phase)
         PH_IDX, PH_INCR, PH_PLAIN, PH_SIZE: begin
            case (parse_phase)
               PH_IDX:   rep_kind = KIND_INDEXED;
               PH_INCR:  rep_kind = KIND_LIT_INCR;
               PH_PLAIN: rep_kind = KIND_LIT_PLAIN;
               default:  rep_kind = KIND_SIZE_UPD;
            endcase
            st = add_group(b);
            if (st == 2)
               ovf = 1'b1;
            else if (st == 0)
               finish_rep(rep_kind, acc_int);
         end
         PH_LEN: begin
            if (b[6:0] != 7'h7f)
               finish_len({57'd0, b[6:0]}, b[7]);
            else
               start_int(b[7] ? PH_LEN_HUF : PH_LEN_RAW, b, 8'h7f);
         end
         PH_LEN_RAW, PH_LEN_HUF: begin
            st = add_group(b);
            if (st == 2)
               ovf = 1'b1;
            else if (st == 0)
               finish_len(acc_int, parse_phase == PH_LEN_HUF);
         end
         PH_DATA: begin
            post_event(KIND_STR_BYTE, 64'd0);
            ev.string_byte = b;
            if (bytes_left != 0)
               bytes_left = bytes_left - 1;
            if (bytes_left == 0) begin
               ev.last_byte = 1'b1;
               after_string();
            end
         end
         PH_SKIP: begin
         end
         default: begin
            if (b[7]) begin
               if (b[6:0] != 7'h7f)
                  finish_rep(KIND_INDEXED, {57'd0, b[6:0]});
               else
                  start_int(PH_IDX, b, 8'h7f);
            end else if (b[6]) begin
               if (b[5:0] != 6'h3f)
                  finish_rep(KIND_LIT_INCR, {58'd0, b[5:0]});
               else
                  start_int(PH_INCR, b, 8'h3f);
            end else if (b[5]) begin
               if (b[4:0] != 5'h1f)
                  finish_rep(KIND_SIZE_UPD, {59'd0, b[4:0]});
               else
                  start_int(PH_SIZE, b, 8'h1f);
            end else begin
               if (b[3:0] != 4'hf)
                  finish_rep(KIND_LIT_PLAIN, {60'd0, b[3:0]});
               else
                  start_int(PH_PLAIN, b, 8'h0f);
            end
         end
      endcase
      if (ovf) begin
         post_event(KIND_ERROR, {32'd0, ERR_OVERFLOW});
         parse_phase = PH_SKIP;
      end
      if (r.block_end) begin
         if (parse_phase != PH_START && parse_phase != PH_SKIP && !ovf)
            post_event(KIND_ERROR, {32'd0, ERR_TRUNCATED});
         clear_state();
      end
   endfunction

   function automatic void note_failure(input string msg);
      if (fails < 10)
         $display("%0t: %s", $time, msg);
      fails = fails + 1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_events.delete();
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_item);
            if (ev_has)
               expected_events.insert(expected_events.size(), ev);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               note_failure($sformatf("unexpected item kind %0d number %0h byte %0h",
                                      rsp_item.kind, rsp_item.number,
                                      rsp_item.string_byte));
            end else begin
               want = expected_events.pop_front();
               if (want.kind !== rsp_item.kind || want.number !== rsp_item.number ||
                   want.string_byte !== rsp_item.string_byte ||
                   want.huffman !== rsp_item.huffman ||
                   want.last_byte !== rsp_item.last_byte)
                  note_failure({
                     $sformatf("mismatch: expected kind %0d num %0h byte %0h huf %0b last %0b,",
                               want.kind, want.number, want.string_byte,
                               want.huffman, want.last_byte),
                     $sformatf(" got kind %0d num %0h byte %0h huf %0b last %0b",
                               rsp_item.kind, rsp_item.number, rsp_item.string_byte,
                               rsp_item.huffman, rsp_item.last_byte)});
            end
         end
      end
      queued = expected_events.size();
   end

endmodule

>>> test/hpack_header_block_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header block parser testbench
// Feeds the parser a short directed run of header block bytes, then random
// header blocks built from well-formed representations, truncated blocks and
// noise, under several idle and stall patterns. The event checker predicts
// and compares every result item; this module reports the verdict.
// ----------------------------------------------------------------------------
module hpack_header_block_parser_top_tb;

   import hpbp_pkg::*;

   localparam logic [7:0]  REP_INDEXED   = 8'h80;
   localparam logic [7:0]  REP_LIT_INCR  = 8'h40;
   localparam logic [7:0]  REP_SIZE_UPD  = 8'h20;
   localparam logic [7:0]  REP_NEVER_IDX = 8'h10;
   localparam logic [7:0]  REP_LIT_PLAIN = 8'h00;
   localparam logic [7:0]  STR_HUFFMAN   = 8'h80;
   localparam logic [7:0]  STR_RAW       = 8'h00;
   localparam logic [63:0] INT_MAX       = (64'd1 << INT_BITS) - 64'd1;
   localparam int          PHASE_BYTES   = 330;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          IDLE_SET [4]  = '{0, 85, 0, 30};
   localparam int          STALL_SET [4] = '{0, 0, 85, 30};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   bit          hold_go       = 1'b0;
   int          hold_count    = 0;
   int unsigned cycle_count   = 0;
   int          bytes_sent    = 0;
   logic [7:0]  blk [$];
   bit          cut;

   logic [8:0] opening [$] = '{
      {8'h80, 1'b0}, {8'hFE, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0},
      {8'h20, 1'b0}, {8'h3F, 1'b0}, {8'hE1, 1'b0}, {8'h1F, 1'b0},
      {8'h40, 1'b0}, {8'h00, 1'b0}, {8'h82, 1'b0}, {8'hAA, 1'b0},
      {8'h55, 1'b0}, {8'h1F, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0},
      {8'h00, 1'b0}, {8'h01, 1'b0}, {8'hFF, 1'b1}, {8'hFF, 1'b0},
      {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
      {8'h7F, 1'b0}, {8'h12, 1'b1}, {8'h0F, 1'b1}
   };

   hpack_header_block_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   hpbp_event_check event_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The single long hold lets the parser fill up and stall its input.
   always @(negedge clock) begin
      if (hold_go && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic e);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= {b, e};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   function automatic void append_byte(input logic [7:0] b);
      blk.insert(blk.size(), b);
   endfunction

   function automatic void put_int(input logic [7:0] flags, input int nbits,
                                   input logic [63:0] v);
      logic [63:0] pmax;
      logic [63:0] rest;
      int          pad;
      pmax = (64'd1 << nbits) - 64'd1;
      if (v < pmax) begin
         append_byte(flags | v[7:0]);
         return;
      end
      append_byte(flags | pmax[7:0]);
      rest = v - pmax;
      pad  = ($urandom_range(7) == 0) ? $urandom_range(1, 10) : 0;
      while (rest >= 128) begin
         append_byte({1'b1, rest[6:0]});
         rest = rest >> 7;
      end
      if (pad == 0) begin
         append_byte({1'b0, rest[6:0]});
      end else begin
         append_byte({1'b1, rest[6:0]});
         repeat (pad - 1) append_byte(8'h80);
         append_byte(8'h00);
      end
   endfunction

   function automatic logic [63:0] pick_int(input int nbits);
      logic [63:0] pmax;
      int          sel;
      pmax = (64'd1 << nbits) - 64'd1;
      sel  = $urandom_range(99);
      if (sel < 55)
         return 64'($urandom) % pmax;
      else if (sel < 85)
         return pmax + 64'($urandom_range(400));
      else if (sel < 92)
         return 64'($urandom);
      else if (sel < 96)
         return INT_MAX - 64'($urandom_range(3));
      else if (sel < 98)
         return INT_MAX + 64'd1 + 64'($urandom_range(1000));
      else
         return {$urandom, $urandom};
   endfunction

   function automatic void put_string();
      logic [63:0] len;
      int          sel;
      sel = $urandom_range(99);
      if (sel < 80)
         len = 64'($urandom_range(12));
      else if (sel < 93)
         len = 64'($urandom_range(100, 260));
      else if (sel < 97)
         len = INT_MAX - 64'($urandom_range(1 << 20));
      else
         len = INT_MAX + 64'd1 + 64'($urandom_range(99));
      put_int($urandom_range(1) ? STR_HUFFMAN : STR_RAW, 7, len);
      if (len <= 300) begin
         repeat (len) append_byte(8'($urandom));
      end else if (len <= INT_MAX) begin
         // Too long to send whole: the block ends inside the string.
         repeat ($urandom_range(4)) append_byte(8'($urandom));
         cut = 1'b1;
      end
   endfunction

   function automatic void put_rep();
      logic [63:0] idx;
      int          sel;
      int          nbits;
      logic [7:0]  flags;
      sel = $urandom_range(99);
      if (sel < 30) begin
         put_int(REP_INDEXED, 7, pick_int(7));
      end else if (sel < 40) begin
         put_int(REP_SIZE_UPD, 5, pick_int(5));
      end else begin
         if (sel < 65) begin
            flags = REP_LIT_INCR;
            nbits = 6;
         end else if (sel < 85) begin
            flags = REP_LIT_PLAIN;
            nbits = 4;
         end else begin
            flags = REP_NEVER_IDX;
            nbits = 4;
         end
         idx = ($urandom_range(99) < 40) ? 64'd0 : pick_int(nbits);
         put_int(flags, nbits, idx);
         if (idx == 0)
            put_string();
         if (!cut)
            put_string();
      end
   endfunction

   task automatic send_block();
      int sel;
      int keep;
      blk.delete();
      cut = 1'b0;
      sel = $urandom_range(99);
      if (sel < 90) begin
         repeat ($urandom_range(1, 4))
            if (!cut)
               put_rep();
         if (sel >= 80 && blk.size() > 1) begin
            keep = $urandom_range(1, blk.size() - 1);
            while (blk.size() > keep)
               void'(blk.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
      end
      foreach (blk[i])
         send_byte(blk[i], i == blk.size() - 1);
      bytes_sent = bytes_sent + blk.size();
   endtask

   initial begin
      int ph;
      int target;
      int pick;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (opening[i])
         send_byte(opening[i][8:1], opening[i][0]);
      wait_drained();
      for (ph = 0; ph < 5; ph++) begin
         @(posedge clock);
         if (ph < 4) begin
            send_idle_pct = IDLE_SET[ph];
            stall_pct     = STALL_SET[ph];
         end
         if (ph == 0)
            hold_go = 1'b1;
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if (ph == 4) begin
               pick          = $urandom_range(3);
               send_idle_pct = IDLE_SET[pick];
               stall_pct     = STALL_SET[pick];
            end
            send_block();
         end
         wait_drained();
      end
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> sim.f
rtl/hpbp_pkg.sv
rtl/hpbp_step.sv
rtl/hpack_header_block_parser_top.sv
test/hpbp_event_check.sv
test/hpack_header_block_parser_top_tb.sv
